FILE: rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Types and constants shared by the tcp connection tracker modules.
// ----------------------------------------------------------------------------
package tct_pkg;

  // flag bit positions in the tcp flag byte
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;
  localparam int unsigned FlagAck = 4;

  localparam logic [15:0] MinHdrBytes = 16'd20;
  localparam logic [48:0] OneSecondUs = 49'd1000000;

  typedef enum logic [2:0] {
    STAT_OTHER_DIR  = 3'd0,
    STAT_BAD_HDR    = 3'd1,
    STAT_UNKNOWN    = 3'd2,
    STAT_OTHER_CONN = 3'd3,
    STAT_TRACKED    = 3'd4,
    STAT_PURE_ACK   = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  direction;
    logic [15:0] segment_length;
    logic [3:0]  data_offset;
    logic [7:0]  tcp_flags;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] window_size;
    logic [47:0] timestamp_us;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] dup_ack_count;
    logic [31:0] highest_seq;
    logic [31:0] highest_ack;
    logic [15:0] last_window;
    logic [31:0] half_packets;
    logic [31:0] total_packets;
    logic [47:0] byte_total;
    logic [47:0] duration_us;
  } result_t;

  // per-direction tracking state
  typedef struct packed {
    logic [15:0] port;
    logic        seq_known;
    logic [31:0] seq_top;
    logic        ack_known;
    logic [31:0] ack_top;
    logic [15:0] dup_count;
    logic [15:0] window;
    logic [31:0] pkt_count;
  } half_t;

  typedef struct packed {
    half_t [1:0] half;
    logic [31:0] all_pkts;
    logic [47:0] byte_count;
    logic [47:0] start_time;
    logic [47:0] end_time;
    logic [47:0] last_time;
  } conn_t;

endpackage

FILE: rtl/tct_update.sv
// ----------------------------------------------------------------------------
// tct_update
// Classifies one segment header and computes the next connection state and
// the result word from the current state.
// ----------------------------------------------------------------------------
module tct_update import tct_pkg::*; (
  input  item_t   item_i,
  input  conn_t   state_i,
  output conn_t   state_o,
  output result_t result_o
);

  logic        s;
  logic        d;
  logic        dir_ok;
  logic [15:0] hlen;
  logic        bad_hdr;
  logic        learn;
  logic        has_syn;
  logic        has_ack;
  logic        match;
  logic        tracked;
  logic [15:0] payload;
  half_t       hc;
  half_t       hn;
  logic [31:0] seq0;
  logic [31:0] seq_diff;
  logic [31:0] ack0;
  logic [31:0] ack_diff;
  logic        ack_upd;
  logic [47:0] start0;
  logic [47:0] end0;
  logic [47:0] last0;
  logic [48:0] now_plus;
  logic [48:0] byte_sum;
  logic        pure_ack;

  always_comb begin
    s       = item_i.direction[0];
    d       = ~item_i.direction[0];
    dir_ok  = ~item_i.direction[1];
    hlen    = {10'd0, item_i.data_offset, 2'b00};
    bad_hdr = (item_i.segment_length < MinHdrBytes) || (hlen > item_i.segment_length);
    has_syn = item_i.tcp_flags[FlagSyn];
    has_ack = item_i.tcp_flags[FlagAck];
    learn   = (state_i.half[d].port == 16'd0);
    // while learning a syn fixes both ports, so the pair matches trivially
    match   = learn || ((item_i.source_port == state_i.half[s].port) &&
                        (item_i.dest_port == state_i.half[d].port));
    tracked = dir_ok && !bad_hdr && (!learn || has_syn) && match;
    payload = item_i.segment_length - hlen;

    hc   = state_i.half[s];
    seq0 = hc.seq_known ? hc.seq_top : item_i.seq_number;
    ack0 = (!hc.ack_known && has_ack) ? item_i.ack_number : hc.ack_top;

    // seq strictly after seq0 modulo 2^32
    seq_diff = seq0 - item_i.seq_number;
    ack_diff = ack0 - item_i.ack_number;
    ack_upd  = has_ack && ((ack_diff == 32'd0) || ack_diff[31]);

    hn           = hc;
    hn.seq_known = 1'b1;
    hn.seq_top   = (seq_diff[31] && !has_syn) ?
                   (item_i.seq_number + {16'd0, payload} - 32'd1) : seq0;
    hn.ack_known = hc.ack_known | has_ack;
    hn.ack_top   = ack_upd ? item_i.ack_number : ack0;
    if (ack_upd) begin
      if (ack_diff == 32'd0) begin
        hn.dup_count = (hc.dup_count == 16'hFFFF) ? hc.dup_count : hc.dup_count + 16'd1;
      end else begin
        hn.dup_count = 16'd0;
      end
    end
    hn.window    = item_i.window_size;
    hn.pkt_count = (hc.pkt_count == 32'hFFFFFFFF) ? hc.pkt_count : hc.pkt_count + 32'd1;
    if (learn) begin
      hn.port = item_i.source_port;
    end

    start0   = learn ? item_i.timestamp_us : state_i.start_time;
    end0     = learn ? item_i.timestamp_us : state_i.end_time;
    last0    = learn ? item_i.timestamp_us : state_i.last_time;
    now_plus = {1'b0, item_i.timestamp_us} + OneSecondUs;
    byte_sum = {1'b0, state_i.byte_count} + {33'd0, payload};

    state_o = state_i;
    if (tracked) begin
      state_o.half[s]    = hn;
      if (learn) begin
        state_o.half[d].port = item_i.dest_port;
      end
      state_o.all_pkts   = (state_i.all_pkts == 32'hFFFFFFFF) ?
                           state_i.all_pkts : state_i.all_pkts + 32'd1;
      state_o.start_time = start0;
      state_o.end_time   = end0;
      state_o.last_time  = last0;
      if (payload != 16'd0) begin
        if ({1'b0, last0} < now_plus) begin
          state_o.end_time = item_i.timestamp_us;
        end
        state_o.last_time  = item_i.timestamp_us;
        state_o.byte_count = byte_sum[48] ? {48{1'b1}} : byte_sum[47:0];
      end
    end

    pure_ack = has_ack && !has_syn && !item_i.tcp_flags[FlagFin] &&
               !item_i.tcp_flags[FlagRst] && (hlen == item_i.segment_length);

    result_o = '0;
    priority if (!dir_ok) begin
      result_o.status = STAT_OTHER_DIR;
    end else if (bad_hdr) begin
      result_o.status = STAT_BAD_HDR;
    end else if (learn && !has_syn) begin
      result_o.status = STAT_UNKNOWN;
    end else if (!match) begin
      result_o.status = STAT_OTHER_CONN;
    end else begin
      result_o.status        = pure_ack ? STAT_PURE_ACK : STAT_TRACKED;
      result_o.dup_ack_count = hn.dup_count;
      result_o.highest_seq   = hn.seq_top;
      result_o.highest_ack   = hn.ack_top;
      result_o.last_window   = hn.window;
      result_o.half_packets  = hn.pkt_count;
      result_o.total_packets = state_o.all_pkts;
      result_o.byte_total    = state_o.byte_count;
      result_o.duration_us   = state_o.end_time - state_o.start_time;
    end
  end

endmodule

FILE: rtl/tcp_connection_tracker.sv
// ----------------------------------------------------------------------------
// tcp_connection_tracker
// Follows one tcp connection in both directions, one header word per item.
// ----------------------------------------------------------------------------
// pipeline: an input word is held in the input register and its result word is
//   captured in the result register, which waits while out_stall_i holds it
// throughput: one word per cycle while the output does not stall, set by the single
//   update pass between the input register and the result register, which also writes the state
// reset: rst_ni clears all tracking state and the valid flags of both stages at once
module tcp_connection_tracker import tct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  direction_i,
  input  logic [15:0] segment_length_i,
  input  logic [3:0]  data_offset_i,
  input  logic [7:0]  tcp_flags_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [15:0] window_size_i,
  input  logic [47:0] timestamp_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] dup_ack_count_o,
  output logic [31:0] highest_seq_o,
  output logic [31:0] highest_ack_o,
  output logic [15:0] last_window_o,
  output logic [31:0] half_packets_o,
  output logic [31:0] total_packets_o,
  output logic [47:0] total_bytes_o,
  output logic [47:0] duration_us_o
);

  item_t   item_q;
  logic    in_valid_q;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  conn_t   state_d;
  conn_t   state_q;
  logic    advance;
  logic    in_fire;

  // input stage moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  tct_update u_update (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.direction      <= direction_i;
      item_q.segment_length <= segment_length_i;
      item_q.data_offset    <= data_offset_i;
      item_q.tcp_flags      <= tcp_flags_i;
      item_q.source_port    <= source_port_i;
      item_q.dest_port      <= dest_port_i;
      item_q.seq_number     <= seq_number_i;
      item_q.ack_number     <= ack_number_i;
      item_q.window_size    <= window_size_i;
      item_q.timestamp_us   <= timestamp_us_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign dup_ack_count_o = res_q.dup_ack_count;
  assign highest_seq_o   = res_q.highest_seq;
  assign highest_ack_o   = res_q.highest_ack;
  assign last_window_o   = res_q.last_window;
  assign half_packets_o  = res_q.half_packets;
  assign total_packets_o = res_q.total_packets;
  assign total_bytes_o   = res_q.byte_total;
  assign duration_us_o   = res_q.duration_us;

endmodule
